// File: design/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion macros shared by the transposition cipher RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check, switched off while reset is held
`define ASSERT_CLK(label, clk, rst_n, prop) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
		else $error("assertion failed in %m");

// Clocked check that also holds during reset
`define ASSERT_ALWAYS(label, clk, prop) \
	label: assert property (@(posedge clk) (prop)) \
		else $error("assertion failed in %m");

`endif

// File: design/ctc_pkg.sv
// ----------------------------------------------------------------------------
// ctc_pkg
// Types, register indexes and helpers for the columnar transposition cipher.
// ----------------------------------------------------------------------------
`default_nettype none

package ctc_pkg;

	localparam int KEY_LEN_W = 5;
	localparam int CFG_IDX_W = 8;

	localparam logic [CFG_IDX_W-1:0] CFG_MODE      = 8'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_KEY_LEN   = 8'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_KEY_LOW   = 8'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_KEY_HIGH  = 8'd3;

	localparam logic MODE_ENCRYPT = 1'b0;
	localparam logic MODE_DECRYPT = 1'b1;

	typedef enum logic [2:0] {
		ST_LOAD,
		ST_RANK,
		ST_WALK_COL,
		ST_WALK_ROW,
		ST_OUT_MAP,
		ST_OUT_BYTE,
		ST_SEND
	} ctc_state_t;

	typedef struct packed {
		logic                 start;
		logic [KEY_LEN_W-1:0] k;
	} rank_req_t;

	typedef struct packed {
		logic busy;
		logic done;
	} rank_rsp_t;

	// Pick key character idx out of the two key words
	function automatic logic [7:0] key_char(input logic [63:0] lo, input logic [63:0] hi,
		input logic [3:0] idx);
		logic [63:0] word;
		begin
			word = idx[3] ? hi : lo;
			return 8'(word >> {idx[2:0], 3'b000});
		end
	endfunction

endpackage

`default_nettype wire

// File: design/ctc_ranker.sv
// ----------------------------------------------------------------------------
// ctc_ranker
// Stable ranking of the key characters with one shared comparator, one pair
// per cycle. Keeps a table from rank to column.
// ----------------------------------------------------------------------------
`default_nettype none

module ctc_ranker #(
	parameter int MAX_KEY = 16,
	localparam int KW = (MAX_KEY > 1) ? $clog2(MAX_KEY) : 1
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire ctc_pkg::rank_req_t req,
	input  wire logic [63:0]       key_lo,
	input  wire logic [63:0]       key_hi,
	input  wire logic [KW-1:0]     rd_rank,
	output logic [KW-1:0]          rd_col,
	output ctc_pkg::rank_rsp_t     rsp
);

	logic          busy_q;
	logic          done_q;
	logic [KW-1:0] a_q;
	logic [KW-1:0] b_q;
	logic [KW-1:0] cnt_q;
	logic [KW-1:0] last_q;
	logic [KW-1:0] rank_col_q [MAX_KEY];

	logic [7:0]    char_a;
	logic [7:0]    char_b;
	logic          below;
	logic [KW-1:0] cnt_next;
	logic          b_last;
	logic          a_last;

	always_comb begin
		char_a   = ctc_pkg::key_char(key_lo, key_hi, 4'(a_q));
		char_b   = ctc_pkg::key_char(key_lo, key_hi, 4'(b_q));
		// equal characters rank left to right
		below    = (char_b < char_a) || ((char_b == char_a) && (b_q < a_q));
		cnt_next = cnt_q + KW'(below);
		b_last   = (b_q == last_q);
		a_last   = (a_q == last_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			a_q    <= '0;
			b_q    <= '0;
			cnt_q  <= '0;
			last_q <= '0;
		end else begin
			done_q <= busy_q && a_last && b_last;
			if (req.start) begin
				busy_q <= 1'b1;
				a_q    <= '0;
				b_q    <= '0;
				cnt_q  <= '0;
				last_q <= KW'(req.k - 1'b1);
			end else if (busy_q) begin
				if (b_last) begin
					b_q   <= '0;
					cnt_q <= '0;
					if (a_last) begin
						busy_q <= 1'b0;
					end else begin
						a_q <= a_q + 1'b1;
					end
				end else begin
					b_q   <= b_q + 1'b1;
					cnt_q <= cnt_next;
				end
			end
		end
	end

	// column a holds rank cnt_next once all pairs for a are seen
	always_ff @(posedge clk) begin
		if (busy_q && b_last) begin
			rank_col_q[cnt_next] <= a_q;
		end
	end

	assign rd_col   = rank_col_q[rd_rank];
	assign rsp.busy = busy_q;
	assign rsp.done = done_q;

endmodule

`default_nettype wire

// File: design/ctc_msg_mem.sv
// ----------------------------------------------------------------------------
// ctc_msg_mem
// Message store and address map, each one write and one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module ctc_msg_mem #(
	parameter int MAX_MESSAGE = 64,
	localparam int AW = $clog2(MAX_MESSAGE)
) (
	input  wire logic          clk,
	input  wire logic          st_we,
	input  wire logic [AW-1:0] st_waddr,
	input  wire logic [7:0]    st_wdata,
	input  wire logic          st_re,
	input  wire logic [AW-1:0] st_raddr,
	output logic [7:0]         st_rdata,
	input  wire logic          mp_we,
	input  wire logic [AW-1:0] mp_waddr,
	input  wire logic [AW-1:0] mp_wdata,
	input  wire logic          mp_re,
	input  wire logic [AW-1:0] mp_raddr,
	output logic [AW-1:0]      mp_rdata
);

	logic [7:0]    store_q [MAX_MESSAGE];
	logic [AW-1:0] map_q   [MAX_MESSAGE];

	always_ff @(posedge clk) begin
		if (st_we) begin
			store_q[st_waddr] <= st_wdata;
		end
		if (st_re) begin
			st_rdata <= store_q[st_raddr];
		end
	end

	always_ff @(posedge clk) begin
		if (mp_we) begin
			map_q[mp_waddr] <= mp_wdata;
		end
		if (mp_re) begin
			mp_rdata <= map_q[mp_raddr];
		end
	end

endmodule

`default_nettype wire

// File: design/columnar_transposition_cipher.sv
// Flow: bytes load at one per cycle while the input is ready; after the final byte the key
// is ranked (one comparison a cycle) and the address map is built, then each result goes
// through a map read, a store read and the output, which may stall.
// Throughput: one message at a time; input is not ready from the final byte until the
// last result is taken. Reset clears control state and registers; the message store and
// maps are left unwritten and need no clearing pass.
// ----------------------------------------------------------------------------
// columnar_transposition_cipher
// Incomplete columnar transposition over a buffered message, encrypt or decrypt.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module columnar_transposition_cipher #(
	parameter int MAX_MESSAGE = 64,
	parameter int MAX_KEY     = 16
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// configuration write channel
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [7:0]  cfg_index,
	input  wire logic [63:0] cfg_data,
	// message in
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [7:0]  s_tdata,   // [7:0] message_byte
	input  wire logic        s_tlast,   // final_byte
	// transposed message out
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [7:0]       m_tdata,   // [7:0] result_byte
	output logic             m_tlast,   // result_last
	output logic             m_tuser    // [0] truncated
);

	localparam int AW  = $clog2(MAX_MESSAGE);
	localparam int CW  = $clog2(MAX_MESSAGE + 1);
	localparam int PW  = $clog2(MAX_MESSAGE + MAX_KEY);
	localparam int KW  = (MAX_KEY > 1) ? $clog2(MAX_KEY) : 1;
	localparam int KNW = $clog2(MAX_KEY + 1);

	// configuration registers
	logic        mode_q;
	logic [4:0]  key_len_q;
	logic [63:0] key_lo_q;
	logic [63:0] key_hi_q;

	ctc_pkg::ctc_state_t state_q, state_d;

	logic [CW-1:0]  count_q;
	logic           ovf_q;
	logic           dec_q;
	logic [KNW-1:0] k_q;
	logic [KW-1:0]  r_q;
	logic [PW-1:0]  plain_q;
	logic [CW-1:0]  pos_q;
	logic [AW-1:0]  i_q;

	ctc_pkg::rank_req_t rank_req;
	ctc_pkg::rank_rsp_t rank_rsp;
	logic [KW-1:0]      rank_col;

	logic          in_acc;
	logic          out_acc;
	logic          store_ok;
	logic [KNW-1:0] k_clamp;
	logic          row_ok;
	logic          r_last;
	logic          i_last;
	logic [7:0]    st_rdata;
	logic [AW-1:0] mp_rdata;
	logic          mp_we;
	logic [AW-1:0] mp_waddr;
	logic [AW-1:0] mp_wdata;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q    <= ctc_pkg::MODE_ENCRYPT;
			key_len_q <= 5'd1;
			key_lo_q  <= '0;
			key_hi_q  <= '0;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				ctc_pkg::CFG_MODE:     mode_q    <= cfg_data[0];
				ctc_pkg::CFG_KEY_LEN:  key_len_q <= cfg_data[4:0];
				ctc_pkg::CFG_KEY_LOW:  key_lo_q  <= cfg_data;
				ctc_pkg::CFG_KEY_HIGH: key_hi_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	always_comb begin
		priority if (key_len_q == 5'd0) begin
			k_clamp = KNW'(1);
		end else if (key_len_q > 5'(MAX_KEY)) begin
			k_clamp = KNW'(MAX_KEY);
		end else begin
			k_clamp = KNW'(key_len_q);
		end
	end

	assign s_tready = (state_q == ctc_pkg::ST_LOAD);
	assign m_tvalid = (state_q == ctc_pkg::ST_SEND);
	assign in_acc   = s_tvalid && s_tready;
	assign out_acc  = m_tvalid && m_tready;
	assign store_ok = (count_q < CW'(MAX_MESSAGE));
	assign row_ok   = (plain_q < PW'(count_q));
	assign r_last   = (r_q == KW'(k_q - 1'b1));
	assign i_last   = (CW'(i_q) == count_q - 1'b1);

	assign rank_req.start = in_acc && s_tlast;
	assign rank_req.k     = ctc_pkg::KEY_LEN_W'(k_clamp);

	// encrypt maps output position to plain index, decrypt the other way round
	assign mp_we    = (state_q == ctc_pkg::ST_WALK_ROW) && row_ok;
	assign mp_waddr = dec_q ? plain_q[AW-1:0] : pos_q[AW-1:0];
	assign mp_wdata = dec_q ? pos_q[AW-1:0] : plain_q[AW-1:0];

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ctc_pkg::ST_LOAD: begin
				if (in_acc && s_tlast) begin
					state_d = ctc_pkg::ST_RANK;
				end
			end
			ctc_pkg::ST_RANK: begin
				if (rank_rsp.done) begin
					state_d = ctc_pkg::ST_WALK_COL;
				end
			end
			ctc_pkg::ST_WALK_COL: state_d = ctc_pkg::ST_WALK_ROW;
			ctc_pkg::ST_WALK_ROW: begin
				if (!row_ok) begin
					state_d = r_last ? ctc_pkg::ST_OUT_MAP : ctc_pkg::ST_WALK_COL;
				end
			end
			ctc_pkg::ST_OUT_MAP:  state_d = ctc_pkg::ST_OUT_BYTE;
			ctc_pkg::ST_OUT_BYTE: state_d = ctc_pkg::ST_SEND;
			ctc_pkg::ST_SEND: begin
				if (out_acc) begin
					state_d = i_last ? ctc_pkg::ST_LOAD : ctc_pkg::ST_OUT_MAP;
				end
			end
			default: state_d = ctc_pkg::ST_LOAD;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ctc_pkg::ST_LOAD;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			ovf_q   <= 1'b0;
			dec_q   <= 1'b0;
			k_q     <= KNW'(1);
			r_q     <= '0;
			plain_q <= '0;
			pos_q   <= '0;
			i_q     <= '0;
		end else begin
			unique case (state_q)
				ctc_pkg::ST_LOAD: begin
					if (in_acc) begin
						// drop bytes past the buffer and flag the message
						if (store_ok) begin
							count_q <= count_q + 1'b1;
						end else begin
							ovf_q <= 1'b1;
						end
						if (s_tlast) begin
							dec_q <= mode_q;
							k_q   <= k_clamp;
							r_q   <= '0;
							pos_q <= '0;
						end
					end
				end
				ctc_pkg::ST_WALK_COL: plain_q <= PW'(rank_col);
				ctc_pkg::ST_WALK_ROW: begin
					if (row_ok) begin
						plain_q <= plain_q + PW'(k_q);
						pos_q   <= pos_q + 1'b1;
					end else if (!r_last) begin
						r_q <= r_q + 1'b1;
					end else begin
						i_q <= '0;
					end
				end
				ctc_pkg::ST_SEND: begin
					if (out_acc) begin
						if (i_last) begin
							count_q <= '0;
							ovf_q   <= 1'b0;
							pos_q   <= '0;
						end else begin
							i_q <= i_q + 1'b1;
						end
					end
				end
				default: ;
			endcase
		end
	end

	ctc_ranker #(
		.MAX_KEY (MAX_KEY)
	) u_ranker (
		.clk     (clk),
		.arst_n  (arst_n),
		.req     (rank_req),
		.key_lo  (key_lo_q),
		.key_hi  (key_hi_q),
		.rd_rank (r_q),
		.rd_col  (rank_col),
		.rsp     (rank_rsp)
	);

	ctc_msg_mem #(
		.MAX_MESSAGE (MAX_MESSAGE)
	) u_mem (
		.clk      (clk),
		.st_we    (in_acc && store_ok),
		.st_waddr (count_q[AW-1:0]),
		.st_wdata (s_tdata),
		.st_re    (state_q == ctc_pkg::ST_OUT_BYTE),
		.st_raddr (mp_rdata),
		.st_rdata (st_rdata),
		.mp_we    (mp_we),
		.mp_waddr (mp_waddr),
		.mp_wdata (mp_wdata),
		.mp_re    (state_q == ctc_pkg::ST_OUT_MAP),
		.mp_raddr (i_q),
		.mp_rdata (mp_rdata)
	);

	assign m_tdata = st_rdata;
	assign m_tlast = i_last;
	assign m_tuser = ovf_q;

	`ASSERT_CLK(a_no_overlap, clk, arst_n, !(s_tready && m_tvalid))
	`ASSERT_CLK(a_pos_bound, clk, arst_n, pos_q <= count_q)
	`ASSERT_CLK(a_send_index, clk, arst_n, m_tvalid |-> (CW'(i_q) < count_q))
	`ASSERT_CLK(a_end_clears, clk, arst_n,
		(m_tvalid && m_tready && m_tlast) |=> (s_tready && count_q == '0 && !ovf_q))
	`ASSERT_CLK(a_rank_done, clk, arst_n,
		rank_rsp.done |-> (state_q == ctc_pkg::ST_RANK && !rank_rsp.busy))

endmodule

`default_nettype wire

// File: tb/columnar_transposition_cipher_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// columnar_transposition_cipher_tb
// Self-checking bench for the transposition cipher. A directed table covers
// identity keys, tied key characters, both modes, clamped key lengths and
// ignored register indexes. Random messages follow, some filling the buffer
// and some overflowing it. Every output byte is checked against bytes typed
// in the table or an in-bench model of column ranking and row/column walk.
// ----------------------------------------------------------------------------

module columnar_transposition_cipher_tb;

	localparam int STORE_DEPTH   = 64;
	localparam int KEY_SLOTS     = 16;
	localparam int RANDOM_ITEMS  = 300;
	localparam int CYCLE_LIMIT   = 400000;
	localparam int SETTLE_CYCLES = 8;

	// indexes outside the register list, written to check they are ignored
	localparam logic [7:0] CFG_SPARE      = 8'd4;
	localparam logic [7:0] CFG_LAST_INDEX = 8'hFF;

	typedef struct packed {
		logic [7:0] data;
		logic       last;
		logic       trunc;
	} cipher_byte_t;

	typedef enum logic {ROW_CFG, ROW_BYTE} row_kind_t;

	typedef struct packed {
		row_kind_t   kind;
		logic [7:0]  idx;
		logic [63:0] value;
		logic        fin;
		logic        typed;
		logic [7:0]  want;
	} stim_row_t;

	localparam int N_DIRECTED = 34;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [7:0]  cfg_index = '0;
	logic [63:0] cfg_data = '0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [7:0]  s_tdata = '0;
	logic        s_tlast = 1'b0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [7:0]  m_tdata;
	logic        m_tlast;
	logic        m_tuser;

	columnar_transposition_cipher dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast),
		.m_tuser  (m_tuser)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// Model state and register copies
	logic        cur_mode = ctc_pkg::MODE_ENCRYPT;
	logic [4:0]  cur_klen = 5'd1;
	logic [63:0] cur_key_lo = '0;
	logic [63:0] cur_key_hi = '0;
	logic [7:0]  held_bytes [STORE_DEPTH];
	logic [6:0]  held_count = '0;
	logic        dropped_any = 1'b0;

	cipher_byte_t awaited_bytes [$];
	cipher_byte_t known_bytes [$];

	int mismatches = 0;
	int messages_closed = 0;
	int truncated_msgs = 0;
	int bytes_checked = 0;
	int reg_writes = 0;
	int cycle_count = 0;
	int burst_left = 0;

	stim_row_t directed_rows [N_DIRECTED] = '{
		// reset settings: one column, so the message comes out unchanged
		'{ROW_BYTE, '0, 64'h01, 1'b0, 1'b1, 8'h01},
		'{ROW_BYTE, '0, 64'hFF, 1'b0, 1'b1, 8'hFF},
		'{ROW_BYTE, '0, 64'h80, 1'b0, 1'b1, 8'h80},
		'{ROW_BYTE, '0, 64'h00, 1'b0, 1'b1, 8'h00},
		'{ROW_BYTE, '0, 64'h7F, 1'b1, 1'b1, 8'h7F},
		'{ROW_BYTE, '0, 64'hAA, 1'b1, 1'b1, 8'hAA},
		// four columns with a tie between characters 1 and 3
		'{ROW_CFG, ctc_pkg::CFG_KEY_LEN, 64'd4, 1'b0, 1'b0, 8'h00},
		'{ROW_CFG, ctc_pkg::CFG_KEY_LOW, 64'h0000_0000_1122_1133, 1'b0, 1'b0, 8'h00},
		'{ROW_BYTE, '0, 64'h41, 1'b0, 1'b0, 8'h00},
		'{ROW_BYTE, '0, 64'h42, 1'b0, 1'b0, 8'h00},
		'{ROW_BYTE, '0, 64'h43, 1'b0, 1'b0, 8'h00},
		'{ROW_BYTE, '0, 64'h44, 1'b0, 1'b0, 8'h00},
		'{ROW_BYTE, '0, 64'h45, 1'b0, 1'b0, 8'h00},
		'{ROW_BYTE, '0, 64'h46, 1'b1, 1'b0, 8'h00},
		'{ROW_CFG, ctc_pkg::CFG_MODE, 64'(ctc_pkg::MODE_DECRYPT), 1'b0, 1'b0, 8'h00},
		'{ROW_BYTE, '0, 64'h47, 1'b0, 1'b0, 8'h00},
		'{ROW_BYTE, '0, 64'h48, 1'b0, 1'b0, 8'h00},
		'{ROW_BYTE, '0, 64'h49, 1'b0, 1'b0, 8'h00},
		'{ROW_BYTE, '0, 64'h4A, 1'b0, 1'b0, 8'h00},
		'{ROW_BYTE, '0, 64'h4B, 1'b0, 1'b0, 8'h00},
		'{ROW_BYTE, '0, 64'h4C, 1'b1, 1'b0, 8'h00},
		// zero key length acts as one column
		'{ROW_CFG, ctc_pkg::CFG_KEY_LEN, 64'd0, 1'b0, 1'b0, 8'h00},
		'{ROW_BYTE, '0, 64'hC3, 1'b0, 1'b1, 8'hC3},
		'{ROW_BYTE, '0, 64'h3C, 1'b1, 1'b1, 8'h3C},
		// oversized key length clamps to sixteen columns
		'{ROW_CFG, ctc_pkg::CFG_KEY_LEN, 64'd31, 1'b0, 1'b0, 8'h00},
		'{ROW_CFG, ctc_pkg::CFG_KEY_LOW, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0, 1'b0, 8'h00},
		'{ROW_CFG, ctc_pkg::CFG_KEY_HIGH, 64'h0001_0203_0405_0607, 1'b0, 1'b0, 8'h00},
		'{ROW_CFG, CFG_SPARE, 64'h1, 1'b0, 1'b0, 8'h00},
		'{ROW_CFG, CFG_LAST_INDEX, 64'h0, 1'b0, 1'b0, 8'h00},
		'{ROW_BYTE, '0, 64'h10, 1'b0, 1'b0, 8'h00},
		'{ROW_BYTE, '0, 64'h20, 1'b0, 1'b0, 8'h00},
		'{ROW_BYTE, '0, 64'h30, 1'b0, 1'b0, 8'h00},
		'{ROW_BYTE, '0, 64'h40, 1'b0, 1'b0, 8'h00},
		'{ROW_BYTE, '0, 64'h50, 1'b1, 1'b0, 8'h00}
	};

	// Rank the key, walk the columns and queue the output bytes of the
	// message now held. Typed-in bytes take the place of predicted ones.
	task automatic transpose_message();
		int unsigned  cols, len, pos, r, c, row, plain, a, b, cnt;
		logic [127:0] key_word;
		logic [3:0]   rank [KEY_SLOTS];
		logic [7:0]   out_bytes [STORE_DEPTH];
		cols = cur_klen;
		if (cols == 0)
			cols = 1;
		if (cols > KEY_SLOTS)
			cols = KEY_SLOTS;
		len = held_count;
		key_word = {cur_key_hi, cur_key_lo};
		for (a = 0; a < cols; a++) begin
			cnt = 0;
			for (b = 0; b < cols; b++) begin
				if (key_word[b*8 +: 8] < key_word[a*8 +: 8] ||
					(key_word[b*8 +: 8] == key_word[a*8 +: 8] && b < a))
					cnt++;
			end
			rank[a] = 4'(cnt);
		end
		pos = 0;
		for (r = 0; r < cols; r++) begin
			for (c = 0; c < cols; c++) begin
				if (rank[c] == 4'(r)) begin
					for (row = 0; row * cols + c < len && pos < len; row++) begin
						plain = row * cols + c;
						if (cur_mode == ctc_pkg::MODE_ENCRYPT)
							out_bytes[pos] = held_bytes[plain];
						else
							out_bytes[plain] = held_bytes[pos];
						pos++;
					end
				end
			end
		end
		if (known_bytes.size() != 0) begin
			foreach (known_bytes[i])
				awaited_bytes.push_back(known_bytes[i]);
			known_bytes.delete();
		end else begin
			for (int i = 0; i < len; i++)
				awaited_bytes.push_back('{data: out_bytes[i], last: (i == len - 1),
					trunc: dropped_any});
		end
		messages_closed++;
		if (dropped_any)
			truncated_msgs++;
		held_count = '0;
		dropped_any = 1'b0;
	endtask

	// Track register writes, message requests and output bytes
	always @(posedge clk or negedge arst_n) begin
		cipher_byte_t want;
		if (!arst_n) begin
			cur_mode = ctc_pkg::MODE_ENCRYPT;
			cur_klen = 5'd1;
			cur_key_lo = '0;
			cur_key_hi = '0;
			held_count = '0;
			dropped_any = 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				reg_writes++;
				case (cfg_index)
					ctc_pkg::CFG_MODE:     cur_mode = cfg_data[0];
					ctc_pkg::CFG_KEY_LEN:  cur_klen = cfg_data[4:0];
					ctc_pkg::CFG_KEY_LOW:  cur_key_lo = cfg_data;
					ctc_pkg::CFG_KEY_HIGH: cur_key_hi = cfg_data;
					default: ;
				endcase
			end
			if (s_tvalid && s_tready) begin
				if (held_count < STORE_DEPTH) begin
					held_bytes[held_count] = s_tdata;
					held_count = held_count + 7'd1;
				end else begin
					dropped_any = 1'b1;
				end
				if (s_tlast)
					transpose_message();
			end
			if (m_tvalid && m_tready) begin
				if (awaited_bytes.size() == 0) begin
					mismatches++;
					$display("%0t: unexpected output byte %02h last %0b truncated %0b",
						$time, m_tdata, m_tlast, m_tuser);
				end else begin
					want = awaited_bytes.pop_front();
					bytes_checked++;
					if (m_tdata !== want.data) begin
						mismatches++;
						$display("%0t: result_byte expected %02h got %02h",
							$time, want.data, m_tdata);
					end
					if (m_tlast !== want.last) begin
						mismatches++;
						$display("%0t: result_last expected %0b got %0b",
							$time, want.last, m_tlast);
					end
					if (m_tuser !== want.trunc) begin
						mismatches++;
						$display("%0t: truncated expected %0b got %0b",
							$time, want.trunc, m_tuser);
					end
				end
			end
		end
	end

	// Output stalls: switch between four patterns, each held for a random stretch
	int ready_style = 0;
	int ready_left = 0;
	int neg_count = 0;

	always @(negedge clk) begin
		if (ready_left == 0) begin
			ready_style = $urandom_range(0, 3);
			ready_left = $urandom_range(20, 80);
		end else begin
			ready_left--;
		end
		case (ready_style)
			0: m_tready <= 1'b1;
			1: m_tready <= ($urandom_range(0, 3) != 0);
			2: m_tready <= (neg_count % 3 == 0);
			default: m_tready <= ($urandom_range(0, 3) == 0);
		endcase
		neg_count++;
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("%0t: run exceeded %0d cycles", $time, CYCLE_LIMIT);
			$display("columnar_transposition_cipher_tb: errors");
			$finish;
		end
	end

	// Drop the request line and hold until every queued output byte has been taken
	task automatic wait_drain();
		@(negedge clk);
		s_tvalid <= 1'b0;
		while (awaited_bytes.size() != 0)
			@(negedge clk);
	endtask

	task automatic write_reg(input logic [7:0] idx, input logic [63:0] value);
		wait_drain();
		repeat (SETTLE_CYCLES) @(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// Present one message byte; bursts of requests are broken by random gaps
	task automatic send_byte(input logic [7:0] b, input logic fin, input logic typed,
		input logic [7:0] want);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 24);
			gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
			repeat (gap) begin
				@(negedge clk);
				s_tvalid <= 1'b0;
			end
		end
		burst_left--;
		@(negedge clk);
		if (typed)
			known_bytes.push_back('{data: want, last: fin, trunc: 1'b0});
		s_tvalid <= 1'b1;
		s_tdata <= b;
		s_tlast <= fin;
		do @(posedge clk); while (!s_tready);
	endtask

	task automatic reconfigure_random();
		int pick;
		logic [63:0] word;
		if ($urandom_range(0, 1))
			write_reg(ctc_pkg::CFG_MODE, 64'($urandom_range(0, 1)));
		if ($urandom_range(0, 1)) begin
			pick = $urandom_range(0, 9);
			case (pick)
				0: write_reg(ctc_pkg::CFG_KEY_LEN, 64'd0);
				1: write_reg(ctc_pkg::CFG_KEY_LEN, 64'd16);
				2: write_reg(ctc_pkg::CFG_KEY_LEN, 64'($urandom_range(17, 31)));
				3: write_reg(ctc_pkg::CFG_KEY_LEN, 64'd1);
				default: write_reg(ctc_pkg::CFG_KEY_LEN, 64'($urandom_range(2, 15)));
			endcase
		end
		for (int w = 0; w < 2; w++) begin
			if ($urandom_range(0, 1)) begin
				// a narrow alphabet forces ties between key characters
				if ($urandom_range(0, 1)) begin
					for (int j = 0; j < 8; j++)
						word[j*8 +: 8] = 8'h41 + 8'($urandom_range(0, 3));
				end else begin
					word = {$urandom, $urandom};
				end
				write_reg((w == 0) ? ctc_pkg::CFG_KEY_LOW : ctc_pkg::CFG_KEY_HIGH, word);
			end
		end
		if ($urandom_range(0, 7) == 0)
			write_reg(8'($urandom_range(CFG_SPARE, CFG_LAST_INDEX)), {$urandom, $urandom});
	endtask

	initial begin
		int items_sent;
		int msg_idx;
		int len;
		int pick;
		items_sent = 0;
		msg_idx = 0;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		foreach (directed_rows[n]) begin
			if (directed_rows[n].kind == ROW_CFG)
				write_reg(directed_rows[n].idx, directed_rows[n].value);
			else
				send_byte(directed_rows[n].value[7:0], directed_rows[n].fin,
					directed_rows[n].typed, directed_rows[n].want);
		end

		// let everything come out before the random part begins
		wait_drain();

		while (items_sent < RANDOM_ITEMS) begin
			if ($urandom_range(0, 2) == 0)
				reconfigure_random();
			if ($urandom_range(0, 4) == 0)
				wait_drain();
			// first fill the buffer exactly, then overflow it
			if (msg_idx == 0) begin
				len = STORE_DEPTH;
			end else if (msg_idx == 1) begin
				len = STORE_DEPTH + 3;
			end else begin
				pick = $urandom_range(0, 9);
				if (pick < 7)
					len = $urandom_range(1, 16);
				else if (pick < 9)
					len = $urandom_range(17, 48);
				else
					len = $urandom_range(60, 72);
			end
			for (int i = 0; i < len; i++)
				send_byte(8'($urandom_range(1, 255)), (i == len - 1), 1'b0, 8'h00);
			items_sent += len;
			msg_idx++;
		end

		@(negedge clk);
		s_tvalid <= 1'b0;
		wait_drain();
		repeat (60) @(negedge clk);
		if (awaited_bytes.size() != 0) begin
			mismatches++;
			$display("%0t: %0d output bytes never arrived", $time, awaited_bytes.size());
		end

		$display("run covered %0d messages (%0d truncated) and %0d register writes",
			messages_closed, truncated_msgs, reg_writes);
		$display("%0d output bytes checked, %0d mismatches", bytes_checked, mismatches);
		if (mismatches == 0)
			$display("columnar_transposition_cipher_tb: clean");
		else
			$display("columnar_transposition_cipher_tb: errors");
		$finish;
	end

endmodule
